>>> rtl/vsd_pkg.sv
`timescale 1ns / 1ps

package vsd_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 64;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned OUT_WIDTH   = 64;
  localparam int unsigned BYTE_WIDTH  = 8;
  localparam int unsigned GROUP_BITS  = 7;
  localparam int unsigned COUNT_WIDTH = 4;
  localparam int unsigned CONT_IDX    = 7;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 4'd15;

  typedef enum logic {
    REQ_UNSIGNED = 1'b0,
    REQ_SIGNED   = 1'b1
  } req_e;

  // Finished value handed from the byte gatherer to the result formatter.
  typedef struct packed {
    logic [OUT_WIDTH-1:0]   acc;
    req_e                   req;
    logic [COUNT_WIDTH-1:0] count;
    logic                   ovf;
  } entry_t;

endpackage

>>> rtl/vsd_front.sv
`timescale 1ns / 1ps

module vsd_front #(
  parameter int unsigned VALUE_WIDTH = vsd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [vsd_pkg::BYTE_WIDTH-1:0] data_byte_i,
  input  vsd_pkg::req_e                req_type_i,
  output logic                         q_push_o,
  output vsd_pkg::entry_t              q_entry_o
);

  localparam int unsigned PosW = $clog2(VALUE_WIDTH + vsd_pkg::GROUP_BITS + 1);
  localparam int unsigned ExtW = VALUE_WIDTH + vsd_pkg::GROUP_BITS;

  logic [VALUE_WIDTH-1:0]          acc_q, acc_d, acc_new;
  logic [PosW-1:0]                 pos_q, pos_d, pos_sum;
  logic [vsd_pkg::COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_new;
  logic                            ovf_q, ovf_d, ovf_new;
  logic [ExtW-1:0]                 ext;
  logic                            last;

  assign last = ~data_byte_i[vsd_pkg::CONT_IDX];

  // Bits shifted past the accumulator top land in the upper group of ext;
  // with the position held at the top the whole payload lands there.
  assign ext     = ExtW'(data_byte_i[vsd_pkg::GROUP_BITS-1:0]) << pos_q;
  assign acc_new = acc_q | ext[VALUE_WIDTH-1:0];
  assign ovf_new = ovf_q | (|ext[ExtW-1:VALUE_WIDTH]);
  assign pos_sum = pos_q + PosW'(vsd_pkg::GROUP_BITS);
  assign cnt_new = (cnt_q == vsd_pkg::COUNT_MAX) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    acc_d = acc_q;
    pos_d = pos_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept_i) begin
      if (last) begin
        acc_d = '0;
        pos_d = '0;
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        acc_d = acc_new;
        pos_d = (pos_sum > PosW'(VALUE_WIDTH)) ? PosW'(VALUE_WIDTH) : pos_sum;
        cnt_d = cnt_new;
        ovf_d = ovf_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pos_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  assign q_push_o        = accept_i & last;
  assign q_entry_o.acc   = vsd_pkg::OUT_WIDTH'(acc_new);
  assign q_entry_o.req   = req_type_i;
  assign q_entry_o.count = cnt_new;
  assign q_entry_o.ovf   = ovf_new;

endmodule

>>> rtl/vsd_queue.sv
`timescale 1ns / 1ps

module vsd_queue #(
  parameter int unsigned DEPTH = vsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vsd_pkg::entry_t wdata_i,
  input  logic            pop_i,
  output vsd_pkg::entry_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  vsd_pkg::entry_t mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/vsd_back.sv
`timescale 1ns / 1ps

module vsd_back #(
  parameter int unsigned VALUE_WIDTH = vsd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_empty_i,
  input  vsd_pkg::entry_t                 q_entry_i,
  output logic                            q_pop_o,
  input  logic                            pop,
  output logic                            empty,
  output logic [vsd_pkg::OUT_WIDTH-1:0]   value_bits_o,
  output logic [vsd_pkg::COUNT_WIDTH-1:0] byte_count_o,
  output logic                            overflow_o
);

  logic                            vld_q;
  logic [VALUE_WIDTH-1:0]          acc, mag, res;
  logic [vsd_pkg::OUT_WIDTH-1:0]   val_q;
  logic [vsd_pkg::COUNT_WIDTH-1:0] cnt_q;
  logic                            ovf_q;
  logic                            load;

  assign acc = q_entry_i.acc[VALUE_WIDTH-1:0];
  assign mag = acc >> 1;

  always_comb begin
    res = acc;
    if (q_entry_i.req == vsd_pkg::REQ_SIGNED) begin
      res = acc[0] ? ('0 - mag) : mag;
    end
  end

  assign load    = ~q_empty_i & (~vld_q | pop);
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (pop) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      val_q <= vsd_pkg::OUT_WIDTH'(res);
      cnt_q <= q_entry_i.count;
      ovf_q <= q_entry_i.ovf;
    end
  end

  assign empty        = ~vld_q;
  assign value_bits_o = val_q;
  assign byte_count_o = cnt_q;
  assign overflow_o   = ovf_q;

endmodule

>>> rtl/varint_stream_decoder.sv
`timescale 1ns / 1ps

// Variable-length integer decoder, one encoded byte per item.
// Input queue side: data_byte_i and req_type_i are taken on a clock edge with
// push high and full low. Bit 7 of the byte marks a continuation; the low 7
// bits are gathered least significant group first. req_type_i of the last
// byte picks an unsigned result or a sign-in-lsb result.
// Result queue side: while empty is low the oldest result sits on
// value_bits_o, byte_count_o and overflow_o; it leaves on an edge with pop
// high. byte_count_o saturates at 15; overflow_o flags dropped nonzero bits.
// Throughput: one byte per cycle while full is low. The gatherer updates its
// accumulator register; a short queue then feeds the result formatter,
// whose negate-and-register stage also serves as the output register.
// A finished value enters the queue, then the output register once it is free.
// When pop is held low the output register and the queue fill; full then
// rises and further bytes wait. While full is high no byte is taken, even
// one that continues a value.
// Reset clears the partial value, the queue and the output register.
module varint_stream_decoder #(
  parameter int unsigned VALUE_WIDTH = vsd_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = vsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [vsd_pkg::BYTE_WIDTH-1:0]  data_byte_i,
  input  logic                            req_type_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [vsd_pkg::OUT_WIDTH-1:0]   value_bits_o,
  output logic [vsd_pkg::COUNT_WIDTH-1:0] byte_count_o,
  output logic                            overflow_o
);

  logic            accept;
  logic            q_push, q_pop, q_full, q_empty;
  vsd_pkg::entry_t q_wdata, q_rdata;

  assign full   = q_full;
  assign accept = push & ~q_full;

  vsd_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .req_type_i (vsd_pkg::req_e'(req_type_i)),
    .q_push_o   (q_push),
    .q_entry_o  (q_wdata)
  );

  vsd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  vsd_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_rdata),
    .q_pop_o     (q_pop),
    .pop         (pop),
    .empty       (empty),
    .value_bits_o(value_bits_o),
    .byte_count_o(byte_count_o),
    .overflow_o  (overflow_o)
  );

endmodule

>>> bench/varint_stream_decoder_test.sv
`timescale 1ns / 1ps

module varint_stream_decoder_test;
  import vsd_pkg::*;

  localparam logic [OUT_WIDTH-1:0] VALUE_MASK =
    {OUT_WIDTH{1'b1}} >> (OUT_WIDTH - VALUE_WIDTH_DEF);
  localparam int unsigned BYTE_TARGET = 1750;

  typedef struct {
    logic [OUT_WIDTH-1:0]   value;
    logic [COUNT_WIDTH-1:0] count;
    logic                   ovf;
  } decoded_t;

  class varint_scoreboard;
    logic [OUT_WIDTH-1:0]   acc;
    int unsigned            bit_pos;
    logic [COUNT_WIDTH-1:0] seen;
    logic                   ovf;
    decoded_t               pending[$];
    int                     errors;

    function new();
      clear_value();
      errors = 0;
    endfunction

    function void clear_value();
      acc = '0;
      bit_pos = 0;
      seen = '0;
      ovf = 1'b0;
    endfunction

    // Fold one accepted byte into the running value; queue a result on the last byte.
    function void note_byte(logic [BYTE_WIDTH-1:0] b, req_e req);
      logic [OUT_WIDTH-1:0] payload;
      logic [OUT_WIDTH-1:0] mag;
      decoded_t             d;
      payload = OUT_WIDTH'(b[GROUP_BITS-1:0]);
      if (bit_pos < VALUE_WIDTH_DEF) begin
        if (VALUE_WIDTH_DEF - bit_pos < GROUP_BITS &&
            (payload >> (VALUE_WIDTH_DEF - bit_pos)) != '0)
          ovf = 1'b1;
        acc = (acc | (payload << bit_pos)) & VALUE_MASK;
        bit_pos = (bit_pos + GROUP_BITS > VALUE_WIDTH_DEF) ? VALUE_WIDTH_DEF
                                                           : bit_pos + GROUP_BITS;
      end else if (payload != '0) begin
        ovf = 1'b1;
      end
      if (seen != COUNT_MAX)
        seen = seen + 1'b1;
      if (b[CONT_IDX])
        return;
      if (req == REQ_SIGNED) begin
        mag = acc >> 1;
        d.value = acc[0] ? ((~mag + 1'b1) & VALUE_MASK) : mag;
      end else begin
        d.value = acc;
      end
      d.count = seen;
      d.ovf = ovf;
      pending.push_back(d);
      clear_value();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50)
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_result(logic [OUT_WIDTH-1:0] value, logic [COUNT_WIDTH-1:0] count,
                      logic ovf_bit);
      decoded_t d;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result value=%h count=%0d ovf=%b",
                         value, count, ovf_bit));
        return;
      end
      d = pending.pop_front();
      if (value !== d.value)
        report($sformatf("value_bits %h, want %h", value, d.value));
      if (count !== d.count)
        report($sformatf("byte_count %0d, want %0d", count, d.count));
      if (ovf_bit !== d.ovf)
        report($sformatf("overflow %b, want %b", ovf_bit, d.ovf));
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   push = 1'b0;
  logic                   full;
  logic [BYTE_WIDTH-1:0]  data_byte_i = '0;
  logic                   req_type_i = 1'b0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [OUT_WIDTH-1:0]   value_bits_o;
  logic [COUNT_WIDTH-1:0] byte_count_o;
  logic                   overflow_o;

  varint_scoreboard sb = new();
  int unsigned      sent = 0;
  bit               steady = 1'b0;

  varint_stream_decoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .req_type_i   (req_type_i),
    .empty        (empty),
    .pop          (pop),
    .value_bits_o (value_bits_o),
    .byte_count_o (byte_count_o),
    .overflow_o   (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("varint_stream_decoder verification failed");
    $finish;
  end

  task automatic send_byte(logic [BYTE_WIDTH-1:0] b, req_e req);
    if (!steady && $urandom_range(99) < 11) begin
      push <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 11)
        @(posedge clk_i);
    end
    push <= 1'b1;
    data_byte_i <= b;
    req_type_i <= req;
    do @(posedge clk_i); while (full);
    sb.note_byte(b, req);
    sent++;
  endtask

  task automatic send_random_value();
    int unsigned           len;
    int unsigned           pick;
    logic [BYTE_WIDTH-1:0] b;
    pick = $urandom_range(99);
    if (pick < 60)
      len = $urandom_range(2, 1);
    else if (pick < 88)
      len = $urandom_range(8, 3);
    else if (pick < 97)
      len = $urandom_range(11, 9);
    else
      len = $urandom_range(20, 12);
    for (int unsigned i = 0; i < len; i++) begin
      b = $urandom_range(255);
      case ($urandom_range(7))
        0: b[GROUP_BITS-1:0] = 7'h00;
        1: b[GROUP_BITS-1:0] = 7'h7F;
        2: b[GROUP_BITS-1:0] = 7'h01;
        default: ;
      endcase
      b[CONT_IDX] = (i != len - 1);
      send_byte(b, req_e'($urandom_range(1)));
    end
  endtask

  always @(posedge clk_i) begin
    if (pop && !empty)
      sb.check_result(value_bits_o, byte_count_o, overflow_o);
    pop <= steady || ($urandom_range(99) >= 11);
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00, REQ_UNSIGNED);
    send_byte(8'h7F, REQ_UNSIGNED);
    send_byte(8'h01, REQ_SIGNED);   // negative zero
    send_byte(8'h7F, REQ_SIGNED);
    send_byte(8'h80, REQ_SIGNED);   // req ignored on continuation
    send_byte(8'h01, REQ_UNSIGNED);
    // all ones to bit 63, zero groups past the top, then a dropped one bit
    repeat (9) send_byte(8'hFF, REQ_UNSIGNED);
    send_byte(8'h81, REQ_UNSIGNED);
    repeat (5) send_byte(8'h80, REQ_UNSIGNED);
    send_byte(8'h01, REQ_SIGNED);

    while (sent < BYTE_TARGET) begin
      steady = (sent >= 700 && sent < 1000);
      send_random_value();
    end
    steady = 1'b0;
    push <= 1'b0;

    while (sb.pending.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0)
      $display("varint_stream_decoder verification clean");
    else
      $display("varint_stream_decoder verification failed");
    $finish;
  end

endmodule

>>> files.f
rtl/vsd_pkg.sv
rtl/vsd_front.sv
rtl/vsd_queue.sv
rtl/vsd_back.sv
rtl/varint_stream_decoder.sv
bench/varint_stream_decoder_test.sv
